### src/cplm_pkg.sv
// Shared types, constants and classification function for the control pilot level monitor.
`default_nettype none

package cplm_pkg;

    localparam int NUM_READINGS = 4;
    localparam int SAMPLE_W     = 12;
    localparam int READING_W    = 8;

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [READING_W-1:0] t_reading;
    typedef logic [1:0]           t_class;
    typedef logic [2:0]           t_reg_index;

    localparam t_class CLASS_12V     = 2'd0;
    localparam t_class CLASS_9V      = 2'd1;
    localparam t_class CLASS_6V      = 2'd2;
    localparam t_class CLASS_UNKNOWN = 2'd3;

    localparam t_reg_index REG_BAND_HIGH_MAX   = 3'd0;
    localparam t_reg_index REG_BAND_HIGH_MIN   = 3'd1;
    localparam t_reg_index REG_BAND_MID_MAX    = 3'd2;
    localparam t_reg_index REG_BAND_MID_MIN    = 3'd3;
    localparam t_reg_index REG_BAND_LOW_MAX    = 3'd4;
    localparam t_reg_index REG_BAND_LOW_MIN    = 3'd5;
    localparam t_reg_index REG_MONITOR_ENABLE  = 3'd6;
    localparam t_reg_index REG_LISTENER_ENABLE = 3'd7;

    localparam t_reading AVG_IDLE = 8'd224;

    // (19a + p) / 20 == a + floor((p - a) / 20); the difference is offset by
    // 260 to stay positive and divided by 20 with a reciprocal multiply.
    localparam int        DIFF_W      = 10;
    localparam int        RECIP_W     = 12;
    localparam int        PROD_W      = DIFF_W + RECIP_W;
    localparam int        DIV_SHIFT   = 16;
    localparam int        QUOT_W      = PROD_W - DIV_SHIFT;
    localparam logic [DIFF_W-1:0]  DIV_OFFSET   = 10'd260;
    localparam logic [RECIP_W-1:0] DIV_RECIP    = 12'd3277;
    localparam t_reading           DIV_OFFSET_Q = 8'd13;

    typedef struct packed {
        t_reading high_max;
        t_reading high_min;
        t_reading mid_max;
        t_reading mid_min;
        t_reading low_max;
        t_reading low_min;
    } t_bands;

    localparam t_bands BANDS_RESET = '{
        high_max: 8'd250,
        high_min: 8'd195,
        mid_max:  8'd180,
        mid_min:  8'd135,
        low_max:  8'd125,
        low_min:  8'd60
    };

    typedef struct packed {
        logic valid;
        logic monitor_en;
        logic listener_en;
        logic listener_wr;
        logic out_free;
    } t_merge_ctl;

    typedef struct packed {
        logic     consume;
        logic     emit;
        t_class   level_class;
        t_reading level_average;
    } t_merge_res;

    function automatic t_class classify(input t_reading v, input t_bands b);
        t_class c;
        if (b.high_min <= v && v <= b.high_max) begin
            c = CLASS_12V;
        end else if (b.mid_min <= v && v <= b.mid_max) begin
            c = CLASS_9V;
        end else if (b.low_min <= v && v <= b.low_max) begin
            c = CLASS_6V;
        end else begin
            c = CLASS_UNKNOWN;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/cplm_lane.sv
// One reading lane: cuts a converter reading to 8 bits and masks errors and out-of-range values.
`default_nettype none

module cplm_lane (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire cplm_pkg::t_sample  i_sample,
    input  wire logic               i_error,
    input  wire cplm_pkg::t_reading i_high_max,
    input  wire cplm_pkg::t_reading i_low_min,
    output cplm_pkg::t_reading      o_value
);
    import cplm_pkg::*;

    t_reading r_value;
    t_reading n_value;
    t_reading w_cut;

    assign w_cut = i_sample[SAMPLE_W-1 -: READING_W];

    always_comb begin
        if (!i_error && w_cut >= i_low_min && w_cut <= i_high_max) begin
            n_value = w_cut;
        end else begin
            n_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

### src/cplm_merge.sv
// Merge stage: window peak, running average update, classification and change detection.
`default_nettype none

module cplm_merge #(
    parameter int LANES = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cplm_pkg::t_reading   i_lane [LANES],
    input  wire cplm_pkg::t_merge_ctl i_ctl,
    input  wire cplm_pkg::t_bands     i_bands,
    output cplm_pkg::t_merge_res      o_res
);
    import cplm_pkg::*;

    t_reading r_avg;
    t_class   r_cur;
    t_class   r_rep;

    t_reading          w_peak;
    logic [DIFF_W-1:0] w_diff;
    logic [PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0] w_quot;
    t_reading          w_upd_avg;
    t_reading          w_new_avg;
    t_class            w_new_class;
    logic              w_emit;
    logic              w_consume;

    always_comb begin
        w_peak = '0;
        for (int i = 0; i < LANES; i++) begin
            if (i_lane[i] > w_peak) begin
                w_peak = i_lane[i];
            end
        end
    end

    assign w_diff    = {{(DIFF_W-READING_W){1'b0}}, w_peak}
                     - {{(DIFF_W-READING_W){1'b0}}, r_avg} + DIV_OFFSET;
    assign w_prod    = PROD_W'(w_diff) * PROD_W'(DIV_RECIP);
    assign w_quot    = w_prod[PROD_W-1:DIV_SHIFT];
    assign w_upd_avg = r_avg + READING_W'(w_quot) - DIV_OFFSET_Q;

    always_comb begin
        if (w_peak != '0) begin
            w_new_avg   = w_upd_avg;
            w_new_class = classify(w_upd_avg, i_bands);
        end else begin
            w_new_avg   = r_avg;
            w_new_class = r_cur;
        end
    end

    assign w_emit    = i_ctl.valid && i_ctl.monitor_en && i_ctl.listener_en
                     && (w_new_class != r_rep);
    assign w_consume = i_ctl.valid && (!w_emit || i_ctl.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= AVG_IDLE;
            r_cur <= CLASS_UNKNOWN;
            r_rep <= CLASS_UNKNOWN;
        end else begin
            if (w_consume) begin
                if (!i_ctl.monitor_en) begin
                    r_avg <= AVG_IDLE;
                end else begin
                    r_avg <= w_new_avg;
                    r_cur <= w_new_class;
                end
            end
            if (i_ctl.listener_wr) begin
                r_rep <= CLASS_UNKNOWN;
            end else if (w_consume && w_emit) begin
                r_rep <= w_new_class;
            end
        end
    end

    assign o_res.consume       = w_consume;
    assign o_res.emit          = w_emit;
    assign o_res.level_class   = w_new_class;
    assign o_res.level_average = w_new_avg;

endmodule

`default_nettype wire

### src/control_pilot_level_monitor.sv
// Top level of the control pilot level monitor: config registers, reading lanes, merge, output.
//
//  channel   dir   transaction content
//  s_*       in    tdata: sample_a..sample_d (12 b each); tuser: error_a..error_d
//  m_*       out   tdata: level_class (2 b), level_average (8 b)
//  cfg_*     in    write: register index, 8-bit data
//
//  One window per cycle while the input is not stalled; a window is registered in the lanes,
//  then the merge runs peak, average update and classification through one reciprocal
//  multiply, and the result is registered at the output.
//  Synchronous active-low reset; the average restarts at 224, classes at unknown.
//  A held result stalls the input only when the next window also yields a result.
`default_nettype none

module control_pilot_level_monitor #(
    parameter int SAMPLES_PER_WINDOW = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // sample_a, sample_b, sample_c, sample_d
    input  wire logic [3:0]  i_s_tuser,  // error_a, error_b, error_c, error_d
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,  // level_class, level_average, zero fill
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata
);
    import cplm_pkg::*;

    localparam int LANES = (SAMPLES_PER_WINDOW > NUM_READINGS) ? NUM_READINGS
                                                               : SAMPLES_PER_WINDOW;

    t_bands     r_bands;
    logic       r_monitor_en;
    logic       r_listener_en;
    logic       r_s1_valid;
    logic       r_m_valid;
    t_class     r_m_class;
    t_reading   r_m_avg;

    logic       w_load;
    logic       w_listener_wr;
    t_reading   w_lane [LANES];
    t_merge_ctl w_ctl;
    t_merge_res w_res;

    assign w_listener_wr = i_cfg_wr_en && (i_cfg_index == REG_LISTENER_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bands       <= BANDS_RESET;
            r_monitor_en  <= 1'b0;
            r_listener_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BAND_HIGH_MAX:   r_bands.high_max <= i_cfg_wdata;
                REG_BAND_HIGH_MIN:   r_bands.high_min <= i_cfg_wdata;
                REG_BAND_MID_MAX:    r_bands.mid_max  <= i_cfg_wdata;
                REG_BAND_MID_MIN:    r_bands.mid_min  <= i_cfg_wdata;
                REG_BAND_LOW_MAX:    r_bands.low_max  <= i_cfg_wdata;
                REG_BAND_LOW_MIN:    r_bands.low_min  <= i_cfg_wdata;
                REG_MONITOR_ENABLE:  r_monitor_en     <= i_cfg_wdata[0];
                REG_LISTENER_ENABLE: r_listener_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = !r_s1_valid || w_res.consume;
    assign w_load     = i_s_tvalid && o_s_tready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cplm_lane u_lane (
            .i_clk      (i_clk),
            .i_load     (w_load),
            .i_sample   (i_s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .i_error    (i_s_tuser[g]),
            .i_high_max (r_bands.high_max),
            .i_low_min  (r_bands.low_min),
            .o_value    (w_lane[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_res.consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign w_ctl.valid       = r_s1_valid;
    assign w_ctl.monitor_en  = r_monitor_en;
    assign w_ctl.listener_en = r_listener_en;
    assign w_ctl.listener_wr = w_listener_wr;
    assign w_ctl.out_free    = !r_m_valid || i_m_tready;

    cplm_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (w_lane),
        .i_ctl   (w_ctl),
        .i_bands (r_bands),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res.consume && w_res.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.consume && w_res.emit) begin
            r_m_class <= w_res.level_class;
            r_m_avg   <= w_res.level_average;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_m_avg, r_m_class};

endmodule

`default_nettype wire

### src/cplm_checker.sv
// Port-level checks for the control pilot level monitor, bound to the top level.
`default_nettype none

module cplm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result dropped or changed");

    a_free_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output slot free");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:10] == 6'b0)
        else $error("result fill bits not zero");

endmodule

bind control_pilot_level_monitor cplm_checker u_cplm_checker (.*);

`default_nettype wire
